>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks disabled while the active-low reset is low, removable at compile
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// shared types and constants of the echo ranger
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int TIMER_WIDTH_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // event kinds carried on the slave tuser
    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_COMPARE = 2'd1,
        FUNC_RISE    = 2'd2,
        FUNC_FALL    = 2'd3
    } t_func;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_PERIOD   = 2'd0,
        CFG_TRIG_WIDTH    = 2'd1,
        CFG_TICKS_PER_MEAS = 2'd2,
        CFG_TIMEOUT       = 2'd3
    } t_cfg_idx;

    // register reset values
    localparam logic [15:0] RST_TICK_PERIOD    = 16'd1000;
    localparam logic [15:0] RST_TRIG_WIDTH     = 16'd15;
    localparam logic [7:0]  RST_TICKS_PER_MEAS = 8'd3;
    localparam logic [15:0] RST_TIMEOUT        = 16'd60000;

    // distance scaling
    localparam longint unsigned NS_PER_US  = 1000;
    localparam longint unsigned US_PER_CM  = 58;

    // control result handed from the sequencer to the distance pipe
    typedef struct packed {
        logic        trigger_level;
        logic        compare_load;
        logic [15:0] compare_value;
        logic        armed;
        logic        dist_update;
    } t_ctl_res;

endpackage

>>> rtl/core/uer_ctl.sv
// ----------------------------------------------------------------------------
// uer_ctl
// event sequencer: trigger, compare scheduling and echo capture state
// ----------------------------------------------------------------------------
module uer_ctl import uer_pkg::*; #(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_func,
    input  logic [15:0]            i_capture_value,
    input  logic [15:0]            i_timer_now,
    input  logic [15:0]            i_trigger_width_ticks,
    input  logic [7:0]             i_ticks_per_measurement,
    input  logic [15:0]            i_timeout_ticks,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_ctl_res               o_res,
    output logic [TIMER_WIDTH-1:0] o_width
);

    // compare values wrap to the timer, then to the 16-bit field
    localparam int          CW       = (TIMER_WIDTH < 16) ? TIMER_WIDTH : 16;
    localparam logic [15:0] CMP_MASK = 16'((32'd1 << CW) - 32'd1);

    logic [7:0]             r_tick_count, n_tick_count;
    logic                   r_waiting_echo, n_waiting_echo;
    logic                   r_echo_high, n_echo_high;
    logic                   r_trigger_active, n_trigger_active;
    logic [TIMER_WIDTH-1:0] r_echo_start, n_echo_start;
    logic                   r_valid;
    t_ctl_res               r_res, n_res;
    logic [TIMER_WIDTH-1:0] r_width, n_width;

    logic                   accept;
    logic [7:0]             tick_inc;
    logic [16:0]            sum_trig;
    logic [16:0]            sum_tmo;
    logic [TIMER_WIDTH-1:0] cap_tw;

    assign o_ready  = !r_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign tick_inc = r_tick_count + 8'd1;
    assign sum_trig = {1'b0, i_timer_now} + {1'b0, i_trigger_width_ticks};
    assign sum_tmo  = {1'b0, i_timer_now} + {1'b0, i_timeout_ticks};
    assign cap_tw   = TIMER_WIDTH'(i_capture_value);

    always_comb begin
        n_tick_count     = r_tick_count;
        n_waiting_echo   = r_waiting_echo;
        n_echo_high      = r_echo_high;
        n_trigger_active = r_trigger_active;
        n_echo_start     = r_echo_start;
        n_res            = '0;
        n_width          = cap_tw - r_echo_start;
        case (t_func'(i_func))
            FUNC_TICK: begin
                n_tick_count = tick_inc;
                if (tick_inc == i_ticks_per_measurement) begin
                    n_tick_count        = '0;
                    n_res.compare_load  = 1'b1;
                    n_res.compare_value = sum_trig[15:0] & CMP_MASK;
                    n_waiting_echo      = 1'b0;
                    n_trigger_active    = 1'b1;
                end
            end
            FUNC_COMPARE: begin
                if (r_trigger_active) begin
                    n_trigger_active    = 1'b0;
                    n_echo_high         = 1'b0;
                    n_waiting_echo      = 1'b1;
                    n_res.compare_load  = 1'b1;
                    n_res.compare_value = sum_tmo[15:0] & CMP_MASK;
                end else begin
                    // timeout
                    n_waiting_echo = 1'b0;
                end
            end
            FUNC_RISE: begin
                if (r_waiting_echo && !r_echo_high) begin
                    n_echo_start = cap_tw;
                    n_echo_high  = 1'b1;
                end
            end
            FUNC_FALL: begin
                if (r_waiting_echo && r_echo_high) begin
                    n_echo_high       = 1'b0;
                    n_waiting_echo    = 1'b0;
                    n_res.dist_update = 1'b1;
                end
            end
            default: ;
        endcase
        n_res.trigger_level = n_trigger_active;
        n_res.armed         = n_waiting_echo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid          <= 1'b0;
            r_tick_count     <= '0;
            r_waiting_echo   <= 1'b0;
            r_echo_high      <= 1'b0;
            r_trigger_active <= 1'b0;
            r_echo_start     <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_tick_count     <= n_tick_count;
                r_waiting_echo   <= n_waiting_echo;
                r_echo_high      <= n_echo_high;
                r_trigger_active <= n_trigger_active;
                r_echo_start     <= n_echo_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res   <= n_res;
            r_width <= n_width;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_width = r_width;

endmodule

>>> rtl/core/uer_dist.sv
// ----------------------------------------------------------------------------
// uer_dist
// echo width to centimetres: multiply, reciprocal divide, saturate
// ----------------------------------------------------------------------------
module uer_dist import uer_pkg::*; #(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_ctl_res               i_res,
    input  logic [TIMER_WIDTH-1:0] i_width,
    input  logic [15:0]            i_tick_period_ns,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_ctl_res               o_res,
    output logic [15:0]            o_distance
);

    localparam int PW = TIMER_WIDTH + 16;

    // width*period/58000, floor of floors; 58000 = 16 * 3625
    localparam longint unsigned NS_PER_CM = NS_PER_US * US_PER_CM;
    localparam int              PRE_SHIFT = 4;
    localparam longint unsigned ODD_DIV   = NS_PER_CM >> PRE_SHIFT;
    // at or above this the distance saturates; below it the product fits 32 bits
    localparam logic [63:0]     SAT_LIMIT = 64'(NS_PER_CM << 16);
    // numerator below 2^28 after the pre-shift, 12 bits cover the odd divisor
    localparam int              NUM_W       = 28;
    localparam int              RECIP_SHIFT = NUM_W + 12;
    localparam int              RECIP_W     = 29;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + ODD_DIV - 64'd1) / ODD_DIV;
    localparam int              QW = NUM_W + RECIP_W;

    logic          r_a_valid, r_b_valid, r_c_valid;
    t_ctl_res      r_a_res, r_b_res, r_c_res;
    logic [PW-1:0] r_a_prod;
    logic          r_b_sat;
    logic [15:0]   r_b_quot;
    logic [15:0]   r_last_dist;

    logic             rdy_a, rdy_b, rdy_c;
    logic [63:0]      prod_ext;
    logic [NUM_W-1:0] numer;
    logic [QW-1:0]    recip_prod;

    assign rdy_c   = !r_c_valid || i_ready;
    assign rdy_b   = !r_b_valid || rdy_c;
    assign rdy_a   = !r_a_valid || rdy_b;
    assign o_ready = rdy_a;

    assign prod_ext   = 64'(r_a_prod);
    assign numer      = prod_ext[NUM_W+PRE_SHIFT-1:PRE_SHIFT];
    assign recip_prod = QW'(numer) * QW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_last_dist <= '0;
        end else begin
            if (rdy_a) begin
                r_a_valid <= i_valid;
            end
            if (rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (rdy_c) begin
                r_c_valid <= r_b_valid;
            end
            if (rdy_c && r_b_valid && r_b_res.dist_update) begin
                r_last_dist <= r_b_sat ? 16'hFFFF : r_b_quot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_a_res  <= i_res;
            r_a_prod <= PW'(i_width) * PW'(i_tick_period_ns);
        end
        if (rdy_b && r_a_valid) begin
            r_b_res  <= r_a_res;
            r_b_sat  <= (prod_ext >= SAT_LIMIT);
            r_b_quot <= recip_prod[RECIP_SHIFT+15:RECIP_SHIFT];
        end
        if (rdy_c && r_b_valid) begin
            r_c_res <= r_b_res;
        end
    end

    assign o_valid    = r_c_valid;
    assign o_res      = r_c_res;
    assign o_distance = r_last_dist;

endmodule

>>> rtl/core/ultrasonic_echo_ranger_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// ranging sequencer: timer events in, trigger/compare/distance status out
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: capture, timer count
//                                               tuser: event kind
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: status after the event
// cfg       in   i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
// one beat in and one beat out per cycle sustained while m_axis_tready stays high; a result
// is registered through the sequencer register, multiply, reciprocal and output stages
// sequencer state changes in the single accept cycle, so events chain back to back
// the four-stage pipe keeps accepting while a result is stalled, until it fills
// reset (synchronous, active low) clears the sequencer, the pipe valids and the
// last distance, and loads the register defaults
//
`include "assert_macros.svh"

module ultrasonic_echo_ranger_unit import uer_pkg::*; #(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // capture_value[15:0], timer_now[31:16]
    input  logic [1:0]            s_axis_tuser,  // func[1:0]
    // master side
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,  // trigger_level[0], compare_load[1],
                                                 // compare_value[17:2], distance_cm[33:18],
                                                 // armed[34], zero[39:35]
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [15:0] r_tick_period_ns;
    logic [15:0] r_trigger_width_ticks;
    logic [7:0]  r_ticks_per_measurement;
    logic [15:0] r_timeout_ticks;

    // sequencer to distance pipe
    logic                   ctl_valid;
    logic                   dist_ready;
    t_ctl_res               ctl_res;
    logic [TIMER_WIDTH-1:0] ctl_width;

    // result
    t_ctl_res    out_res;
    logic [15:0] out_distance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period_ns        <= RST_TICK_PERIOD;
            r_trigger_width_ticks   <= RST_TRIG_WIDTH;
            r_ticks_per_measurement <= RST_TICKS_PER_MEAS;
            r_timeout_ticks         <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TICK_PERIOD:    r_tick_period_ns        <= i_cfg_data;
                CFG_TRIG_WIDTH:     r_trigger_width_ticks   <= i_cfg_data;
                CFG_TICKS_PER_MEAS: r_ticks_per_measurement <= i_cfg_data[7:0];
                CFG_TIMEOUT:        r_timeout_ticks         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // event sequencer, also the input register stage
    uer_ctl #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_ctl (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_valid                 (s_axis_tvalid),
        .o_ready                 (s_axis_tready),
        .i_func                  (s_axis_tuser),
        .i_capture_value         (s_axis_tdata[15:0]),
        .i_timer_now             (s_axis_tdata[31:16]),
        .i_trigger_width_ticks   (r_trigger_width_ticks),
        .i_ticks_per_measurement (r_ticks_per_measurement),
        .i_timeout_ticks         (r_timeout_ticks),
        .o_valid                 (ctl_valid),
        .i_ready                 (dist_ready),
        .o_res                   (ctl_res),
        .o_width                 (ctl_width)
    );

    // distance pipe, ends in the output register
    uer_dist #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_dist (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (ctl_valid),
        .o_ready          (dist_ready),
        .i_res            (ctl_res),
        .i_width          (ctl_width),
        .i_tick_period_ns (r_tick_period_ns),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_res            (out_res),
        .o_distance       (out_distance)
    );

    assign m_axis_tdata = {5'b0, out_res.armed, out_distance, out_res.compare_value,
                           out_res.compare_load, out_res.trigger_level};

    // no compare value without a load
    `ASSERT_IMPLY(a_cmp_zero_unloaded, i_clk, i_rst_n,
        m_axis_tvalid && !out_res.compare_load, out_res.compare_value == 16'd0)
    // trigger high and echo wait never overlap
    `ASSERT_IMPLY(a_trig_not_armed, i_clk, i_rst_n,
        m_axis_tvalid, !(out_res.trigger_level && out_res.armed))
    // a load only comes with trigger start or trigger end
    `ASSERT_IMPLY(a_load_has_cause, i_clk, i_rst_n,
        m_axis_tvalid && out_res.compare_load, out_res.trigger_level || out_res.armed)
    // distance only moves when a new result beat is presented
    `ASSERT_NEXT(a_dist_holds_stalled, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready, $stable(out_distance))

endmodule
